// ===== rtl/wrms_pkg.sv =====
// ----------------------------------------------------------------------------
// wrms_pkg: shared types and constants of the windowed RMS level meter
// Field widths, configuration register codes and the shared ALU opcodes.
// ----------------------------------------------------------------------------
package wrms_pkg;

	localparam int CH_W       = 3;   // channel field
	localparam int SAMPLE_W   = 16;  // signed sample
	localparam int MAG_W      = 17;  // |sample| up to 32768
	localparam int SQ_W       = 31;  // square up to 2^30
	localparam int LEVEL_W    = 16;  // rms level up to 32768
	localparam int ACT_W      = 4;   // active channel count
	localparam int CNT_W      = 5;   // sequencer step counter
	localparam int ROOT_STEPS = 16;  // one root bit per step

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FREEZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b1;

	localparam logic [ACT_W-1:0] ACTIVE_RESET = 4'd8;

	typedef enum logic [1:0] {
		ALU_ADD = 2'b01,
		ALU_SUB = 2'b10
	} alu_op_t;

endpackage

// ===== rtl/wrms_if.sv =====
// ----------------------------------------------------------------------------
// wrms_if: valid/ready channels of the windowed RMS level meter
// Sample channel into the meter and level channel out of it.
// ----------------------------------------------------------------------------
interface wrms_sample_if import wrms_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CH_W-1:0]            channel;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       end_of_block;

	modport source (output valid, channel, sample, end_of_block, input ready);
	modport sink   (input valid, channel, sample, end_of_block, output ready);
endinterface

interface wrms_level_if import wrms_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    level_channel;
	logic [LEVEL_W-1:0] rms_level;

	modport source (output valid, level_channel, rms_level, input ready);
	modport sink   (input valid, level_channel, rms_level, output ready);
endinterface

// ===== rtl/windowed_rms_level_meter_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_level_meter_unit: multi-channel sliding-window RMS meter
//
// Beats on "samples" carry a channel, a signed Q1.15 sample and an
// end_of_block flag. Each kept sample is squared, replaces the oldest square
// in its channel's window and updates that channel's running sum. A kept beat with
// end_of_block set yields one beat on "levels": floor(sqrt(sum / WINDOW_SIZE)).
// Beats are dropped while freeze is set or when the channel is not below
// active_channels (or CHANNELS); a dropped beat is still accepted.
// Sequencing: a kept beat without end_of_block holds ready low after acceptance
// through the read, subtract and add states. With end_of_block the shared adder then
// runs 16 root steps, plus 31 division steps when WINDOW_SIZE is not a power
// of two; the level is then registered from the emit state.
// Reset: the window store is swept to zero, one entry per cycle, over all
// CHANNELS*WINDOW_SIZE entries (8192 by default); samples.ready stays low.
// Configuration writes are taken at any time, also during the sweep.
// The level sits in an output register: the next sample is accepted while it
// waits; a second level waits in the sequencer until the register is free.
// ----------------------------------------------------------------------------
module windowed_rms_level_meter_unit import wrms_pkg::*; #(
	parameter int WINDOW_SIZE = 1024,
	parameter int CHANNELS    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	wrms_sample_if.sink           samples,
	wrms_level_if.source          levels
);

	localparam int  POS_W    = $clog2(WINDOW_SIZE);
	localparam int  SUM_W    = SQ_W + POS_W;
	localparam int  DEPTH    = CHANNELS * WINDOW_SIZE;
	localparam int  ADDR_W   = $clog2(DEPTH);
	localparam int  CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam bit  WIN_POW2 = (WINDOW_SIZE & (WINDOW_SIZE - 1)) == 0;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_READ  = 8'b0000_0100,
		S_SUB   = 8'b0000_1000,
		S_ADD   = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_ROOT  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic                freeze_q;
	logic [ACT_W-1:0]    active_q;
	logic [SUM_W-1:0]    sums_q [CHANNELS];
	logic [POS_W-1:0]    pos_q  [CHANNELS];
	logic                out_valid_q;

	logic [CH_W-1:0]     ch_q;
	logic                eob_q;
	logic [MAG_W-1:0]    mag_q;
	logic [SQ_W-1:0]     sq_q;
	logic [ADDR_W-1:0]   slot_q;
	logic [SQ_W-1:0]     rd_q;
	logic [SUM_W-1:0]    acc_q;
	logic [SQ_W-1:0]     aux_q;
	logic [SQ_W-1:0]     root_q;
	logic [CH_W-1:0]     lvl_ch_q;
	logic [LEVEL_W-1:0]  lvl_q;

	logic [SQ_W-1:0]     mem [DEPTH];

	logic                accept;
	logic                drop;
	logic [MAG_W-1:0]    sx;
	logic [MAG_W-1:0]    mag;
	logic [2*MAG_W-1:0]  sq_full;
	logic [CH_IDX_W-1:0] ch_idx;
	logic [POS_W-1:0]    pos_cur;
	logic [ADDR_W-1:0]   slot;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [SQ_W-1:0]     mem_wdata;
	logic [SQ_W-1:0]     root_bit;
	logic                emit_load;

	alu_op_t             alu_op;
	logic [SUM_W-1:0]    alu_a;
	logic [SUM_W-1:0]    alu_b;
	logic [SUM_W-1:0]    alu_y;
	logic                alu_borrow;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign drop          = freeze_q
		|| ({1'b0, samples.channel} >= active_q)
		|| (32'(samples.channel) >= CHANNELS);

	assign sx      = {samples.sample[SAMPLE_W-1], samples.sample};
	assign mag     = samples.sample[SAMPLE_W-1] ? (~sx + MAG_W'(1)) : sx;
	assign sq_full = mag_q * mag_q;

	assign ch_idx  = CH_IDX_W'(ch_q);
	assign pos_cur = pos_q[ch_idx];
	assign slot    = ADDR_W'(ch_q) * ADDR_W'(WINDOW_SIZE) + ADDR_W'(pos_cur);

	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_SUB);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : slot_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : sq_q;

	// bit = 4^cnt; root bits always lie above it, so root + bit == root | bit
	assign root_bit  = SQ_W'(1) << {cnt_q[3:0], 1'b0};
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || levels.ready);

	assign levels.valid         = out_valid_q;
	assign levels.level_channel = lvl_ch_q;
	assign levels.rms_level     = lvl_q;

	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = acc_q;
		alu_b  = '0;
		unique case (state_q)
			S_SUB: begin
				alu_a = sums_q[ch_idx];
				alu_b = SUM_W'(rd_q);
			end
			S_ADD: begin
				alu_op = ALU_ADD;
				alu_b  = SUM_W'(sq_q);
			end
			S_DIV: begin
				alu_a = {acc_q[SUM_W-2:0], aux_q[SQ_W-1]};
				alu_b = SUM_W'(WINDOW_SIZE);
			end
			S_ROOT: begin
				alu_b = SUM_W'(root_q | root_bit);
			end
			default: begin
			end
		endcase
	end

	wrms_alu #(
		.W      (SUM_W)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.y      (alu_y),
		.borrow (alu_borrow)
	);

	// window store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freeze_q <= 1'b0;
			active_q <= ACTIVE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FREEZE: freeze_q <= cfg_wdata[0];
				REG_ACTIVE: active_q <= cfg_wdata[ACT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				sums_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (levels.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && !drop) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					if ({1'b0, pos_cur} + (POS_W+1)'(1) == (POS_W+1)'(WINDOW_SIZE)) begin
						pos_q[ch_idx] <= '0;
					end else begin
						pos_q[ch_idx] <= pos_cur + POS_W'(1);
					end
					state_q <= S_ADD;
				end
				S_ADD: begin
					sums_q[ch_idx] <= alu_y;
					if (!eob_q) begin
						state_q <= S_IDLE;
					end else if (WIN_POW2) begin
						cnt_q   <= CNT_W'(ROOT_STEPS - 1);
						state_q <= S_ROOT;
					end else begin
						cnt_q   <= CNT_W'(SQ_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(ROOT_STEPS - 1);
						state_q <= S_ROOT;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_ROOT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q  <= samples.channel;
			eob_q <= samples.end_of_block;
			mag_q <= mag;
		end
		if (state_q == S_READ) begin
			sq_q   <= sq_full[SQ_W-1:0];
			slot_q <= slot;
		end
		if (state_q == S_SUB) begin
			acc_q <= alu_y;
		end
		if (state_q == S_ADD) begin
			root_q <= '0;
			if (WIN_POW2) begin
				acc_q <= alu_y >> POS_W;
			end else begin
				// remainder starts as the high part, which is below WINDOW_SIZE
				acc_q <= alu_y >> SQ_W;
				aux_q <= alu_y[SQ_W-1:0];
			end
		end
		if (state_q == S_DIV) begin
			aux_q <= {aux_q[SQ_W-2:0], ~alu_borrow};
			if (cnt_q == '0) begin
				acc_q <= SUM_W'({aux_q[SQ_W-2:0], ~alu_borrow});
			end else if (!alu_borrow) begin
				acc_q <= alu_y;
			end else begin
				acc_q <= alu_a;
			end
		end
		if (state_q == S_ROOT) begin
			if (!alu_borrow) begin
				acc_q  <= alu_y;
				root_q <= (root_q >> 1) | root_bit;
			end else begin
				root_q <= root_q >> 1;
			end
		end
		if (emit_load) begin
			lvl_ch_q <= ch_q;
			lvl_q    <= root_q[LEVEL_W-1:0];
		end
	end

	// the window sum always holds the square being removed
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUB) |-> !alu_borrow)
		else $error("window sum below the square it replaces");

	// a finished root never exceeds full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (root_q <= SQ_W'(32768)))
		else $error("rms root above full scale");

	// a level waiting on a busy output register stays in the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && !levels.ready) |=> (state_q == S_EMIT))
		else $error("level loaded over an untaken beat");

	// window position stays inside the window
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUB) |-> ({1'b0, pos_cur} < (POS_W+1)'(WINDOW_SIZE)))
		else $error("window position out of range");

endmodule

// ===== rtl/wrms_alu.sv =====
// ----------------------------------------------------------------------------
// wrms_alu: shared add/subtract unit
// Serves the running-sum update, the long division and the square root.
// ----------------------------------------------------------------------------
module wrms_alu import wrms_pkg::*; #(
	parameter int W = 41
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] y,
	output logic         borrow
);

	logic         sub;
	logic [W:0]   full;

	assign sub    = (op == ALU_SUB);
	assign full   = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
	assign y      = full[W-1:0];
	// no carry out on a subtract means a < b
	assign borrow = sub & ~full[W];

endmodule
